### hw/rtl/frmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record min/max statistics package
// Shared types, statistic codes and the statistic selection function.
// ----------------------------------------------------------------------------
package frmm_pkg;

    localparam int unsigned TimeDeltaW = 16;
    localparam int unsigned AltitudeW  = 21;
    localparam int unsigned TempW      = 16;
    localparam int unsigned PressureW  = 18;
    localparam int unsigned AccelW     = 13;
    localparam int unsigned DurationW  = 31;
    localparam int unsigned StatCodeW  = 4;
    localparam int unsigned StatValueW = 32;

    // Statistic codes, in emission order
    typedef enum logic [StatCodeW-1:0] {
        STAT_DURATION   = 4'd0,
        STAT_ALT_MIN    = 4'd1,
        STAT_ALT_MAX    = 4'd2,
        STAT_TEMP_MIN   = 4'd3,
        STAT_TEMP_MAX   = 4'd4,
        STAT_PRESS_MIN  = 4'd5,
        STAT_PRESS_MAX  = 4'd6,
        STAT_ACCX_MIN   = 4'd7,
        STAT_ACCX_MAX   = 4'd8,
        STAT_ACCY_MIN   = 4'd9,
        STAT_ACCY_MAX   = 4'd10,
        STAT_ACCZ_MIN   = 4'd11,
        STAT_ACCZ_MAX   = 4'd12
    } stat_code_t;

    // Full set of running statistics
    typedef struct packed {
        logic        [DurationW-1:0] duration;
        logic signed [AltitudeW-1:0] alt_low;
        logic signed [AltitudeW-1:0] alt_high;
        logic signed [TempW-1:0]     temp_low;
        logic signed [TempW-1:0]     temp_high;
        logic        [PressureW-1:0] press_low;
        logic        [PressureW-1:0] press_high;
        logic signed [AccelW-1:0]    accx_low;
        logic signed [AccelW-1:0]    accx_high;
        logic signed [AccelW-1:0]    accy_low;
        logic signed [AccelW-1:0]    accy_high;
        logic signed [AccelW-1:0]    accz_low;
        logic signed [AccelW-1:0]    accz_high;
    } stats_t;

    // Pick one statistic and extend it to the output width
    function automatic logic [StatValueW-1:0] stat_value(input stats_t s,
                                                         input stat_code_t c);
        logic [StatValueW-1:0] v;
        case (c)
            STAT_DURATION:  v = StatValueW'(s.duration);
            STAT_ALT_MIN:   v = StatValueW'(s.alt_low);
            STAT_ALT_MAX:   v = StatValueW'(s.alt_high);
            STAT_TEMP_MIN:  v = StatValueW'(s.temp_low);
            STAT_TEMP_MAX:  v = StatValueW'(s.temp_high);
            STAT_PRESS_MIN: v = StatValueW'(s.press_low);
            STAT_PRESS_MAX: v = StatValueW'(s.press_high);
            STAT_ACCX_MIN:  v = StatValueW'(s.accx_low);
            STAT_ACCX_MAX:  v = StatValueW'(s.accx_high);
            STAT_ACCY_MIN:  v = StatValueW'(s.accy_low);
            STAT_ACCY_MAX:  v = StatValueW'(s.accy_high);
            STAT_ACCZ_MIN:  v = StatValueW'(s.accz_low);
            STAT_ACCZ_MAX:  v = StatValueW'(s.accz_high);
            default:        v = '0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/frmm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record min/max statistics channels
// Valid/ready channels for sensor record items and statistic items.
// ----------------------------------------------------------------------------
interface frmm_rec_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      first_record;
    logic                                      last_record;
    logic        [frmm_pkg::TimeDeltaW-1:0]    time_delta;
    logic signed [frmm_pkg::AltitudeW-1:0]     altitude;
    logic signed [frmm_pkg::TempW-1:0]         temperature;
    logic        [frmm_pkg::PressureW-1:0]     pressure;
    logic signed [frmm_pkg::AccelW-1:0]        accel_x;
    logic signed [frmm_pkg::AccelW-1:0]        accel_y;
    logic signed [frmm_pkg::AccelW-1:0]        accel_z;

    modport source (
        output valid, first_record, last_record, time_delta, altitude,
               temperature, pressure, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, first_record, last_record, time_delta, altitude,
               temperature, pressure, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface frmm_stat_if;
    logic                                  valid;
    logic                                  ready;
    logic        [frmm_pkg::StatCodeW-1:0]  stat_code;
    logic signed [frmm_pkg::StatValueW-1:0] stat_value;
    logic                                  end_of_run;

    modport source (
        output valid, stat_code, stat_value, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, stat_code, stat_value, end_of_run,
        output ready
    );
endinterface

### hw/rtl/frmm_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record min/max statistics update stage
// Registers each record, folds it into the running statistics and hands a
// snapshot to the emitter when the record closes a run.
// ----------------------------------------------------------------------------
module frmm_stats (
    input  logic              clk,
    input  logic              rst_n,
    frmm_rec_if.sink          rec,
    input  logic              snap_ready,
    output logic              snap_load,
    output frmm_pkg::stats_t  snap_data
);

    // Input register
    logic                                  s1_valid_reg, s1_valid_next;
    logic                                  s1_first_reg, s1_last_reg;
    logic        [frmm_pkg::TimeDeltaW-1:0] s1_td_reg;
    logic signed [frmm_pkg::AltitudeW-1:0]  s1_alt_reg;
    logic signed [frmm_pkg::TempW-1:0]      s1_temp_reg;
    logic        [frmm_pkg::PressureW-1:0]  s1_press_reg;
    logic signed [frmm_pkg::AccelW-1:0]     s1_accx_reg, s1_accy_reg, s1_accz_reg;

    frmm_pkg::stats_t stats_reg, stats_next, base;
    logic [frmm_pkg::DurationW:0] dur_sum;
    logic advance, rec_take;

    // A last record waits in the input register until the emitter is free
    assign advance   = s1_valid_reg && (!s1_last_reg || snap_ready);
    assign rec.ready = !s1_valid_reg || advance;
    assign rec_take  = rec.valid && rec.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rec_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            s1_first_reg <= rec.first_record;
            s1_last_reg  <= rec.last_record;
            s1_td_reg    <= rec.time_delta;
            s1_alt_reg   <= rec.altitude;
            s1_temp_reg  <= rec.temperature;
            s1_press_reg <= rec.pressure;
            s1_accx_reg  <= rec.accel_x;
            s1_accy_reg  <= rec.accel_y;
            s1_accz_reg  <= rec.accel_z;
        end
    end

    // Statistics update: clear on first record, saturating duration, extremes
    always_comb
    begin
        base       = s1_first_reg ? '0 : stats_reg;
        stats_next = base;
        dur_sum    = {1'b0, base.duration} + (frmm_pkg::DurationW + 1)'(s1_td_reg);
        stats_next.duration = dur_sum[frmm_pkg::DurationW] ? '1
                                                           : dur_sum[frmm_pkg::DurationW-1:0];
        if (s1_alt_reg < base.alt_low)     stats_next.alt_low    = s1_alt_reg;
        if (s1_alt_reg > base.alt_high)    stats_next.alt_high   = s1_alt_reg;
        if (s1_temp_reg < base.temp_low)   stats_next.temp_low   = s1_temp_reg;
        if (s1_temp_reg > base.temp_high)  stats_next.temp_high  = s1_temp_reg;
        if (s1_press_reg < base.press_low) stats_next.press_low  = s1_press_reg;
        if (s1_press_reg > base.press_high) stats_next.press_high = s1_press_reg;
        if (s1_accx_reg < base.accx_low)   stats_next.accx_low   = s1_accx_reg;
        if (s1_accx_reg > base.accx_high)  stats_next.accx_high  = s1_accx_reg;
        if (s1_accy_reg < base.accy_low)   stats_next.accy_low   = s1_accy_reg;
        if (s1_accy_reg > base.accy_high)  stats_next.accy_high  = s1_accy_reg;
        if (s1_accz_reg < base.accz_low)   stats_next.accz_low   = s1_accz_reg;
        if (s1_accz_reg > base.accz_high)  stats_next.accz_high  = s1_accz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stats_reg <= '0;
        else if (advance)
            stats_reg <= stats_next;
    end

    // Snapshot to the emitter includes the closing record
    assign snap_load = advance && s1_last_reg;
    assign snap_data = stats_next;

endmodule

### hw/rtl/frmm_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record min/max statistics emitter
// Holds a snapshot of the statistics and sends it out as a run of 13 items
// through an output register.
// ----------------------------------------------------------------------------
module frmm_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_load,
    input  frmm_pkg::stats_t  snap_data,
    output logic              snap_ready,
    frmm_stat_if.source       stat
);

    frmm_pkg::stats_t snap_reg;
    logic busy_reg, busy_next;
    logic [frmm_pkg::StatCodeW-1:0] idx_reg, idx_next;

    logic out_valid_reg, out_valid_next;
    logic [frmm_pkg::StatCodeW-1:0]  code_reg;
    logic [frmm_pkg::StatValueW-1:0] value_reg;
    logic eor_reg;

    logic fill, last_fill, is_last;

    // Output slot can take a new item when empty or being drained
    assign is_last    = (idx_reg == frmm_pkg::STAT_ACCZ_MAX);
    assign fill       = busy_reg && (!out_valid_reg || stat.ready);
    assign last_fill  = fill && is_last;
    assign snap_ready = !busy_reg || last_fill;

    // Run sequencing
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (snap_load)
        begin
            busy_next = 1'b1;
            idx_next  = frmm_pkg::STAT_DURATION;
        end
        else if (last_fill)
        begin
            busy_next = 1'b0;
        end
        else if (fill)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fill)
            out_valid_next = 1'b1;
        else if (stat.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Snapshot and output payload
    always_ff @(posedge clk)
    begin
        if (snap_load)
            snap_reg <= snap_data;
        if (fill)
        begin
            code_reg  <= idx_reg;
            value_reg <= frmm_pkg::stat_value(snap_reg, frmm_pkg::stat_code_t'(idx_reg));
            eor_reg   <= is_last;
        end
    end

    assign stat.valid      = out_valid_reg;
    assign stat.stat_code  = code_reg;
    assign stat.stat_value = value_reg;
    assign stat.end_of_run = eor_reg;

endmodule

### hw/rtl/flight_record_min_max_stats_core.sv
`timescale 1ns / 1ps
// A record enters the input register, then the statistics register; a run's
// first item passes the input, snapshot and output registers. Throughput: one
// record per cycle, but a closing record waits in the input register while a
// run is under way; a run's 13 items leave one per cycle while stat is ready.
// Reset: rst_n clears all statistics to zero and empties both channels.
// ----------------------------------------------------------------------------
// Flight record min/max statistics core
// Running minimum, maximum and saturating duration over logged sensor records.
// ----------------------------------------------------------------------------
module flight_record_min_max_stats_core (
    input  logic          clk,
    input  logic          rst_n,
    frmm_rec_if.sink      rec,
    frmm_stat_if.source   stat
);

    logic             snap_ready;
    logic             snap_load;
    frmm_pkg::stats_t snap_data;

    frmm_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (rec),
        .snap_ready (snap_ready),
        .snap_load  (snap_load),
        .snap_data  (snap_data)
    );

    frmm_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_load  (snap_load),
        .snap_data  (snap_data),
        .snap_ready (snap_ready),
        .stat       (stat)
    );

endmodule

### tb/frmm_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record statistics checker
// Watches the record and statistic channels. It keeps its own running
// minimum, maximum and saturating duration for each record taken, queues the
// 13 statistic items that a closing record calls for, and compares every
// statistic item taken against the oldest one queued.
// ----------------------------------------------------------------------------
module frmm_stats_checker (
    input  logic        clk,
    input  logic        rst_n,
    frmm_rec_if         rec,
    frmm_stat_if        stat,
    output int unsigned fail_count,
    output int unsigned outstanding
);
    import frmm_pkg::*;

    localparam logic [StatValueW-1:0] DurationMax = 32'h7FFF_FFFF;

    typedef struct packed {
        stat_code_t            code;
        logic [StatValueW-1:0] value;
        logic                  closing;
    } stat_item_t;

    stat_item_t stat_q[$];

    // Running statistics, X/Y/Z in index order for acceleration
    logic        [DurationW-1:0] duration;
    logic signed [AltitudeW-1:0] alt_lo, alt_hi;
    logic signed [TempW-1:0]     temp_lo, temp_hi;
    logic        [PressureW-1:0] press_lo, press_hi;
    logic signed [AccelW-1:0]    acc_lo [3];
    logic signed [AccelW-1:0]    acc_hi [3];

    initial fail_count = 0;
    initial outstanding = 0;

    function void clear_stats();
        duration = '0;
        alt_lo   = '0;
        alt_hi   = '0;
        temp_lo  = '0;
        temp_hi  = '0;
        press_lo = '0;
        press_hi = '0;
        for (int k = 0; k < 3; k++)
        begin
            acc_lo[k] = '0;
            acc_hi[k] = '0;
        end
    endfunction

    // Fold one record into the running statistics
    function void fold_record();
        logic        [StatValueW-1:0] sum;
        logic signed [AccelW-1:0]     acc [3];
        acc[0] = rec.accel_x;
        acc[1] = rec.accel_y;
        acc[2] = rec.accel_z;
        if (rec.first_record)
            clear_stats();
        // duration saturates rather than wrapping
        sum = StatValueW'(duration) + StatValueW'(rec.time_delta);
        duration = (sum > DurationMax) ? DurationMax[DurationW-1:0] : sum[DurationW-1:0];
        if (rec.altitude < alt_lo)    alt_lo = rec.altitude;
        if (rec.altitude > alt_hi)    alt_hi = rec.altitude;
        if (rec.temperature < temp_lo) temp_lo = rec.temperature;
        if (rec.temperature > temp_hi) temp_hi = rec.temperature;
        // unsigned: the minimum never leaves zero
        if (rec.pressure < press_lo)  press_lo = rec.pressure;
        if (rec.pressure > press_hi)  press_hi = rec.pressure;
        for (int k = 0; k < 3; k++)
        begin
            if (acc[k] < acc_lo[k]) acc_lo[k] = acc[k];
            if (acc[k] > acc_hi[k]) acc_hi[k] = acc[k];
        end
    endfunction

    function void queue_stat(stat_code_t c, logic [StatValueW-1:0] v);
        stat_item_t e;
        e.code    = c;
        e.value   = v;
        e.closing = (c == STAT_ACCZ_MAX);
        stat_q.push_back(e);
    endfunction

    // Statistic run in emission order; signed values sign extend
    function void queue_run();
        queue_stat(STAT_DURATION,  StatValueW'(duration));
        queue_stat(STAT_ALT_MIN,   StatValueW'(alt_lo));
        queue_stat(STAT_ALT_MAX,   StatValueW'(alt_hi));
        queue_stat(STAT_TEMP_MIN,  StatValueW'(temp_lo));
        queue_stat(STAT_TEMP_MAX,  StatValueW'(temp_hi));
        queue_stat(STAT_PRESS_MIN, StatValueW'(press_lo));
        queue_stat(STAT_PRESS_MAX, StatValueW'(press_hi));
        queue_stat(STAT_ACCX_MIN,  StatValueW'(acc_lo[0]));
        queue_stat(STAT_ACCX_MAX,  StatValueW'(acc_hi[0]));
        queue_stat(STAT_ACCY_MIN,  StatValueW'(acc_lo[1]));
        queue_stat(STAT_ACCY_MAX,  StatValueW'(acc_hi[1]));
        queue_stat(STAT_ACCZ_MIN,  StatValueW'(acc_lo[2]));
        queue_stat(STAT_ACCZ_MAX,  StatValueW'(acc_hi[2]));
    endfunction

    // Results are checked before the record of the same edge is folded in
    always @(posedge clk)
    begin : watch
        stat_item_t want;
        if (!rst_n)
        begin
            clear_stats();
            stat_q.delete();
        end
        else
        begin
            if (stat.valid && stat.ready)
            begin
                if (stat_q.size() == 0)
                begin
                    $display("%0t: unexpected statistic item, code %0d value %0d",
                             $time, stat.stat_code, stat.stat_value);
                    fail_count++;
                end
                else
                begin
                    want = stat_q.pop_front();
                    if (stat.stat_code !== want.code)
                    begin
                        $display("%0t: stat_code expected %0d actual %0d",
                                 $time, want.code, stat.stat_code);
                        fail_count++;
                    end
                    if (stat.stat_value !== want.value)
                    begin
                        $display("%0t: stat_value (code %0d) expected %0d actual %0d",
                                 $time, want.code, $signed(want.value), stat.stat_value);
                        fail_count++;
                    end
                    if (stat.end_of_run !== want.closing)
                    begin
                        $display("%0t: end_of_run (code %0d) expected %0b actual %0b",
                                 $time, want.code, want.closing, stat.end_of_run);
                        fail_count++;
                    end
                end
            end
            if (rec.valid && rec.ready)
            begin
                fold_record();
                if (rec.last_record)
                    queue_run();
            end
        end
        outstanding = stat_q.size();
    end

endmodule

### tb/tb_flight_record_min_max_stats_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight record min/max statistics core testbench
// Drives sensor records in flights opened and closed by the record flags,
// with random gaps on the record side and random stalls on the statistic
// side. A directed part covers field extremes, both flags, no flags and
// emission before any opening record. The checker alongside predicts and
// compares every item.
// ----------------------------------------------------------------------------
module tb_flight_record_min_max_stats_core;
    import frmm_pkg::*;

    typedef struct packed {
        logic                        first_record;
        logic                        last_record;
        logic        [TimeDeltaW-1:0] time_delta;
        logic signed [AltitudeW-1:0]  altitude;
        logic signed [TempW-1:0]      temperature;
        logic        [PressureW-1:0]  pressure;
        logic signed [AccelW-1:0]     accel_x;
        logic signed [AccelW-1:0]     accel_y;
        logic signed [AccelW-1:0]     accel_z;
    } record_t;

    localparam int unsigned RandomItems = 320;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned records_sent;
    bit          steady;

    frmm_rec_if  rec_ch ();
    frmm_stat_if stat_ch ();

    flight_record_min_max_stats_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_ch),
        .stat  (stat_ch)
    );

    frmm_stats_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec         (rec_ch),
        .stat        (stat_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    // Field value biased towards zero, all ones and the signed extremes
    function automatic logic [31:0] pick_field(int unsigned w);
        logic [31:0] mask;
        mask = (32'd1 << w) - 32'd1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            2:       return 32'd1 << (w - 1);
            3:       return (32'd1 << (w - 1)) - 32'd1;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic record_t random_record(bit first, bit last);
        record_t r;
        r.first_record = first;
        r.last_record  = last;
        r.time_delta   = TimeDeltaW'(pick_field(TimeDeltaW));
        r.altitude     = AltitudeW'(pick_field(AltitudeW));
        r.temperature  = TempW'(pick_field(TempW));
        r.pressure     = PressureW'(pick_field(PressureW));
        r.accel_x      = AccelW'(pick_field(AccelW));
        r.accel_y      = AccelW'(pick_field(AccelW));
        r.accel_z      = AccelW'(pick_field(AccelW));
        return r;
    endfunction

    function automatic record_t make_record(bit first, bit last, int td, int alt,
                                            int temp, int press, int ax, int ay, int az);
        record_t r;
        r.first_record = first;
        r.last_record  = last;
        r.time_delta   = TimeDeltaW'(td);
        r.altitude     = AltitudeW'(alt);
        r.temperature  = TempW'(temp);
        r.pressure     = PressureW'(press);
        r.accel_x      = AccelW'(ax);
        r.accel_y      = AccelW'(ay);
        r.accel_z      = AccelW'(az);
        return r;
    endfunction

    // Present one record, hold it until taken, then maybe leave a gap
    task automatic send_record(input record_t r);
        int unsigned gap;
        @(negedge clk);
        rec_ch.valid        <= 1'b1;
        rec_ch.first_record <= r.first_record;
        rec_ch.last_record  <= r.last_record;
        rec_ch.time_delta   <= r.time_delta;
        rec_ch.altitude     <= r.altitude;
        rec_ch.temperature  <= r.temperature;
        rec_ch.pressure     <= r.pressure;
        rec_ch.accel_x      <= r.accel_x;
        rec_ch.accel_y      <= r.accel_y;
        rec_ch.accel_z      <= r.accel_z;
        @(posedge clk);
        while (!rec_ch.ready)
            @(posedge clk);
        records_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            rec_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait for every queued statistic to come out
    task automatic drain();
        @(negedge clk);
        rec_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_flight(int unsigned len, bit opened, bit closed);
        for (int unsigned i = 0; i < len; i++)
            send_record(random_record(opened && i == 0, closed && i == len - 1));
    endtask

    // Statistic side: open stretches, some long, broken by stalls
    initial
    begin
        int unsigned open_len;
        int unsigned hold;
        stat_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            open_len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 12);
            @(negedge clk);
            stat_ch.ready <= 1'b1;
            repeat (open_len - 1) @(negedge clk);
            hold = steady ? 0 : pick_gap();
            if (hold != 0)
            begin
                @(negedge clk);
                stat_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    // Record side stimulus and verdict
    initial
    begin
        int unsigned target;
        int unsigned len;
        rst_n               = 1'b0;
        steady              = 1'b0;
        records_sent        = 0;
        rec_ch.valid        = 1'b0;
        rec_ch.first_record = 1'b0;
        rec_ch.last_record  = 1'b0;
        rec_ch.time_delta   = '0;
        rec_ch.altitude     = '0;
        rec_ch.temperature  = '0;
        rec_ch.pressure     = '0;
        rec_ch.accel_x      = '0;
        rec_ch.accel_y      = '0;
        rec_ch.accel_z      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // accumulation straight from reset, no opening record
        send_record(make_record(0, 0, 65535, -1048576, 32767, 262143, -4096, 4095, 0));
        send_record(make_record(0, 1, 1, 1048575, -32768, 0, 4095, -4096, -1));
        // emission leaves the statistics in place
        send_record(make_record(0, 1, 0, 0, 0, 0, 0, 0, 0));
        // both flags at once
        send_record(make_record(1, 1, 0, 0, 0, 0, 0, 0, 0));
        // all positive: minimums stay at zero
        send_record(make_record(1, 0, 100, 12345, 250, 101325, 100, 200, 300));
        // neither flag: folded in silently
        send_record(make_record(0, 0, 200, -7, -40, 99000, -100, -200, -300));
        send_record(make_record(0, 1, 65535, 3, 1, 1, 0, 0, 0));
        send_record(make_record(1, 1, 65535, -1, -1, 262143, -1, -1, -1));
        send_record(make_record(1, 1, 65535, 1048575, 32767, 262143, 4095, 4095, 4095));
        drain();

        // random flights; some unopened, some left unclosed
        target = records_sent + RandomItems;
        while (records_sent < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_flight(len, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
            if ($urandom_range(0, 15) == 0)
                drain();
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
        end
        steady = 1'b0;

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
